// ===== rtl/i2cseq_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register transaction sequencer package
// Shared types, codes and defaults for the sequencer and its submodules.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  localparam int BufferDepthDefault = 16;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_TX_RDY  = 3'd1;
  localparam logic [2:0] OP_RX_BYTE = 3'd2;
  localparam logic [2:0] OP_FAULT   = 3'd3;
  localparam logic [2:0] OP_LOAD    = 3'd4;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_BUS   = 2'd1;
  localparam logic [1:0] FAULT_PHASE = 2'd2;

  localparam logic [1:0] REG_ADDRESS    = 2'd0;
  localparam logic [1:0] REG_IS_WRITE   = 2'd1;
  localparam logic [1:0] REG_BYTE_COUNT = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ADDR    = 3'd1,
    PH_RESTART = 3'd2,
    PH_TX      = 3'd3,
    PH_RX      = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] register_address;
    logic       is_write;
    logic [4:0] byte_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic [3:0] load_index;
  } in_item_t;

  typedef struct packed {
    logic       tx_write;
    logic [7:0] tx_byte;
    logic       rx_write;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic       stop_request;
    logic       restart_request;
    logic       done_res;
    logic [1:0] fault;
  } out_item_t;

endpackage

// ===== rtl/i2c_register_transaction_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// I2C register transaction sequencer
// Steps one register read or write transaction over a byte-level bus engine.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register; its result is
// registered once the result register is free. Throughput: one item per
// cycle unless out_ready stalls; the input refills as the result drains.
// Reset: synchronous; phase idle, counters and registers cleared. The write
// store is not cleared and holds its old contents until loaded.
module i2c_register_transaction_sequencer_top #(
  parameter int BUFFER_DEPTH = i2cseq_pkg::BufferDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cseq_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cseq_pkg::out_item_t out_item
);
  import i2cseq_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PW = $clog2(BUFFER_DEPTH + 1);

  cfg_t          cfg;
  logic          inq_valid;
  in_item_t      inq_item;
  logic          step;
  out_item_t     result;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  logic          we;

  assign step     = inq_valid && (!out_valid || out_ready);
  assign in_ready = !inq_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADDRESS:    cfg.register_address <= cfg_data;
        REG_IS_WRITE:   cfg.is_write         <= cfg_data[0];
        REG_BYTE_COUNT: cfg.byte_count       <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

  i2cseq_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW(AW),
    .PW(PW)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(step),
    .item(inq_item),
    .cfg(cfg),
    .rdata(rdata),
    .raddr(raddr),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .result(result)
  );

  i2cseq_store #(
    .DEPTH(BUFFER_DEPTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

// ===== rtl/i2cseq_store.sv =====
// ----------------------------------------------------------------------------
// Write data store
// One write port and one registered read port; a write to the address being
// read is forwarded to the read data.
// ----------------------------------------------------------------------------
module i2cseq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/i2cseq_core.sv =====
// ----------------------------------------------------------------------------
// Transaction sequencer core
// Holds phase, remaining count and buffer position, and forms one result
// for each item it steps.
// ----------------------------------------------------------------------------
module i2cseq_core #(
  parameter int BUFFER_DEPTH = 16,
  parameter int AW = 4,
  parameter int PW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  i2cseq_pkg::in_item_t item,
  input  i2cseq_pkg::cfg_t     cfg,
  input  logic [7:0]           rdata,
  output logic [AW-1:0]        raddr,
  output logic                 we,
  output logic [AW-1:0]        waddr,
  output logic [7:0]           wdata,
  output i2cseq_pkg::out_item_t result
);
  import i2cseq_pkg::*;

  localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);
  localparam logic [4:0]    SAT_P   = (BUFFER_DEPTH > 31) ? 5'd31 : 5'(BUFFER_DEPTH);

  phase_t        phase, phase_next;
  logic [4:0]    remaining, remaining_next;
  logic [PW-1:0] position, position_next;
  logic          can_move;
  logic [4:0]    rem_after;
  logic [PW+3:0] pos_wide;
  logic [AW+3:0] lidx_wide;

  assign can_move  = (remaining != 5'd0) && (position < DEPTH_P);
  assign rem_after = can_move ? remaining - 5'd1 : 5'd0;
  assign pos_wide  = {4'b0, position};
  assign lidx_wide = {{AW{1'b0}}, item.load_index};

  assign we    = step && (item.op == OP_LOAD) &&
                 ({{PW{1'b0}}, item.load_index} < {4'b0, DEPTH_P});
  assign waddr = lidx_wide[AW-1:0];
  assign wdata = item.data_byte;
  assign raddr = (position_next < DEPTH_P) ? position_next[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      remaining <= '0;
      position  <= '0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      position  <= position_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    position_next  = position;
    if (step) begin
      case (item.op)
        OP_START: begin
          if (phase == PH_IDLE) begin
            phase_next     = PH_ADDR;
            remaining_next = (cfg.byte_count > SAT_P) ? SAT_P : cfg.byte_count;
            position_next  = '0;
          end
        end
        OP_TX_RDY: begin
          case (phase)
            PH_ADDR:    phase_next = cfg.is_write ? PH_TX : PH_RESTART;
            PH_RESTART: phase_next = PH_RX;
            PH_TX: begin
              if (can_move) begin
                position_next  = position + PW'(1);
                remaining_next = remaining - 5'd1;
              end else begin
                phase_next     = PH_IDLE;
                remaining_next = '0;
                position_next  = '0;
              end
            end
            default: ;
          endcase
        end
        OP_RX_BYTE: begin
          if (phase == PH_RX) begin
            remaining_next = rem_after;
            if (can_move) begin
              position_next = position + PW'(1);
            end
            if (rem_after == 5'd0) begin
              phase_next    = PH_IDLE;
              position_next = '0;
            end
          end
        end
        OP_FAULT: begin
          phase_next     = PH_IDLE;
          remaining_next = '0;
          position_next  = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result = '0;
    case (item.op)
      OP_START: begin
        if (phase != PH_IDLE) begin
          result.fault = FAULT_PHASE;
        end
      end
      OP_TX_RDY: begin
        case (phase)
          PH_ADDR: begin
            result.tx_write = 1'b1;
            result.tx_byte  = cfg.register_address;
          end
          PH_RESTART: begin
            result.restart_request = 1'b1;
            result.stop_request    = (remaining <= 5'd1);
          end
          PH_TX: begin
            if (can_move) begin
              result.tx_write = 1'b1;
              result.tx_byte  = rdata;
            end else begin
              result.stop_request = 1'b1;
              result.done_res     = 1'b1;
            end
          end
          default: result.fault = FAULT_PHASE;
        endcase
      end
      OP_RX_BYTE: begin
        if (phase == PH_RX) begin
          if (can_move) begin
            result.rx_write = 1'b1;
            result.rx_index = pos_wide[3:0];
            result.rx_byte  = item.data_byte;
          end
          result.stop_request = (rem_after == 5'd1);
          result.done_res     = (rem_after == 5'd0);
        end else begin
          result.fault = FAULT_PHASE;
        end
      end
      OP_FAULT: result.fault = FAULT_BUS;
      OP_LOAD:  ;
      default:  result.fault = FAULT_PHASE;
    endcase
  end

endmodule

// ===== rtl/i2cseq_checker.sv =====
// ----------------------------------------------------------------------------
// Sequencer port checker
// Watches the top level's ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module i2cseq_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input i2cseq_pkg::out_item_t out_item
);
  import i2cseq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input held off while the result side was free");

  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.fault != FAULT_NONE) |->
      !out_item.tx_write && !out_item.rx_write && !out_item.done_res &&
      !out_item.stop_request && !out_item.restart_request)
    else $error("faulted result carries an action");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.tx_write && out_item.rx_write) &&
      !(out_item.done_res && out_item.restart_request) &&
      (out_item.fault <= FAULT_PHASE))
    else $error("conflicting result flags");

endmodule

bind i2c_register_transaction_sequencer_top i2cseq_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item(out_item)
);

// ===== test/i2cseq_check_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C sequencer scoreboard
// Tracks the sequencer's phase, counters, registers and write store, predicts
// the bus action caused by each accepted item and checks the block's results.
// ----------------------------------------------------------------------------
package i2cseq_check_pkg;

  import i2cseq_pkg::*;

  localparam int StoreDepth = BufferDepthDefault;
  localparam int ReportCap  = 100;

  class sequencer_scoreboard;

    logic [7:0] register_address;
    logic       is_write;
    logic [4:0] byte_count;
    phase_t     phase;
    logic [4:0] remaining;
    logic [4:0] position;
    logic [7:0] write_store [StoreDepth];
    out_item_t  awaited_actions [$];
    int         mismatches;

    function new();
      register_address = '0;
      is_write         = 1'b0;
      byte_count       = '0;
      mismatches       = 0;
      foreach (write_store[i]) write_store[i] = '0;
      go_idle();
    endfunction

    function void go_idle();
      phase     = PH_IDLE;
      remaining = '0;
      position  = '0;
    endfunction

    function void set_register(logic [1:0] index, logic [7:0] value);
      case (index)
        REG_ADDRESS: begin
          register_address = value;
        end
        REG_IS_WRITE: begin
          is_write = value[0];
        end
        REG_BYTE_COUNT: begin
          byte_count = value[4:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return awaited_actions.size();
    endfunction

    function void note_event(in_item_t ev);
      out_item_t act;
      act = '0;
      case (ev.op)
        OP_START: begin
          if (phase == PH_IDLE) begin
            phase     = PH_ADDR;
            remaining = (byte_count > StoreDepth) ? 5'(StoreDepth) : byte_count;
            position  = '0;
          end else begin
            act.fault = FAULT_PHASE;
          end
        end
        OP_TX_RDY: begin
          if (phase == PH_ADDR) begin
            act.tx_write = 1'b1;
            act.tx_byte  = register_address;
            phase        = is_write ? PH_TX : PH_RESTART;
          end else if (phase == PH_RESTART) begin
            act.restart_request = 1'b1;
            if (remaining <= 1) act.stop_request = 1'b1;
            phase = PH_RX;
          end else if (phase == PH_TX) begin
            if (remaining != 0 && position < StoreDepth) begin
              act.tx_write = 1'b1;
              act.tx_byte  = write_store[position[3:0]];
              position++;
              remaining--;
            end else begin
              act.stop_request = 1'b1;
              act.done_res     = 1'b1;
              go_idle();
            end
          end else begin
            act.fault = FAULT_PHASE;
          end
        end
        OP_RX_BYTE: begin
          if (phase == PH_RX) begin
            if (remaining != 0 && position < StoreDepth) begin
              act.rx_write = 1'b1;
              act.rx_index = position[3:0];
              act.rx_byte  = ev.data_byte;
              position++;
              remaining--;
            end else begin
              remaining = '0;
            end
            if (remaining == 1) begin
              act.stop_request = 1'b1;
            end else if (remaining == 0) begin
              act.done_res = 1'b1;
              go_idle();
            end
          end else begin
            act.fault = FAULT_PHASE;
          end
        end
        OP_FAULT: begin
          act.fault = FAULT_BUS;
          go_idle();
        end
        OP_LOAD: begin
          write_store[ev.load_index] = ev.data_byte;
        end
        default: begin
          act.fault = FAULT_PHASE;
        end
      endcase
      awaited_actions.push_back(act);
    endfunction

    function void report_mismatch(string what);
      if (mismatches < ReportCap) $display("%0t: mismatch: %s", $time, what);
      mismatches++;
    endfunction

    function void compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
    endfunction

    function void check_action(out_item_t got);
      out_item_t want;
      if (awaited_actions.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
        return;
      end
      want = awaited_actions.pop_front();
      compare_field("tx_write", got.tx_write, want.tx_write);
      compare_field("tx_byte", got.tx_byte, want.tx_byte);
      compare_field("rx_write", got.rx_write, want.rx_write);
      compare_field("rx_index", got.rx_index, want.rx_index);
      compare_field("rx_byte", got.rx_byte, want.rx_byte);
      compare_field("stop_request", got.stop_request, want.stop_request);
      compare_field("restart_request", got.restart_request, want.restart_request);
      compare_field("done_res", got.done_res, want.done_res);
      compare_field("fault", got.fault, want.fault);
    endfunction

  endclass

endpackage

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// I2C register transaction sequencer testbench
// Drives directed and random event streams, mostly well-formed read and
// write transactions with noise and aborts, over several register settings
// and flow-control patterns, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import i2cseq_pkg::*;
  import i2cseq_check_pkg::*;

  localparam int         ClockHalf     = 5;
  localparam int         ResetCycles   = 8;
  localparam int         QuietLimit    = 2000;
  localparam int         HoldCycles    = 400;
  localparam int         SettleCycles  = 4;
  localparam int         PhaseCount    = 12;
  localparam int         PhaseItems    = 125;
  localparam int         PlanFixed     = 8;
  localparam logic [2:0] OP_UNUSED_TOP = 3'd7;
  localparam logic [1:0] REG_UNUSED    = 2'd3;

  localparam logic [7:0] PlanAddr [PlanFixed] =
    '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h00, 8'h81};
  localparam logic PlanWrite [PlanFixed] =
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam logic [4:0] PlanCount [PlanFixed] =
    '{5'd0, 5'd1, 5'd16, 5'd16, 5'd31, 5'd31, 5'd0, 5'd1};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  sequencer_scoreboard sb = new();

  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct     = 0;
  int                  hold_requests = 0;
  int                  hold_served   = 0;
  int                  hold_left     = 0;
  int                  quiet_cycles  = 0;
  int unsigned         events_sent   = 0;
  bit [StoreDepth-1:0] loaded_entries = '0;
  logic                cur_write;
  logic [4:0]          cur_count;

  i2c_register_transaction_sequencer_top i_dut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_ready,
    .in_item,
    .out_valid,
    .out_ready,
    .out_item
  );

  always #(ClockHalf) clk = ~clk;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready   <= 1'b0;
      hold_served <= hold_requests;
      hold_left   <= HoldCycles;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_action(out_item);
      if (in_valid && in_ready) sb.note_event(in_item);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(logic [2:0] op, logic [7:0] data, logic [3:0] index);
    in_item_t it;
    it.op         = op;
    it.data_byte  = data;
    it.load_index = index;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (it.op == OP_LOAD) loaded_entries[it.load_index] = 1'b1;
    events_sent++;
  endtask

  task automatic send_op(logic [2:0] op);
    send_item(make_item(op, 8'($urandom), 4'($urandom)));
  endtask

  task automatic write_register(logic [1:0] index, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(index, value);
  endtask

  // Any write transaction under this setting reads the store from entry zero
  // upwards, so every entry it can reach is loaded before the first start.
  task automatic configure(logic [7:0] address, logic write, logic [4:0] count);
    write_register(REG_ADDRESS, address);
    write_register(REG_IS_WRITE, {7'd0, write});
    write_register(REG_BYTE_COUNT, {3'd0, count});
    cfg_we    <= 1'b0;
    cur_write = write;
    cur_count = count;
    if (write) begin
      for (int i = 0; i < StoreDepth && i < count; i++) begin
        if (!loaded_entries[i]) send_item(make_item(OP_LOAD, 8'($urandom), 4'(i)));
      end
    end
  endtask

  task automatic finish_phase();
    send_op(OP_FAULT);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_noise(bit receiving);
    case ($urandom_range(3))
      0: send_op(OP_LOAD);
      1: send_op(3'($urandom_range(OP_UNUSED_TOP, OP_LOAD + 1)));
      2: send_op(OP_START);
      default: send_op(receiving ? OP_TX_RDY : OP_RX_BYTE);
    endcase
  endtask

  task automatic run_transaction();
    int unsigned n;
    int unsigned abort_at;
    logic [2:0]  steps [$];
    n     = (cur_count > StoreDepth) ? StoreDepth : cur_count;
    steps = {OP_START, OP_TX_RDY};
    if (cur_write) begin
      repeat (n + 1) steps.push_back(OP_TX_RDY);
    end else begin
      steps.push_back(OP_TX_RDY);
      repeat ((n == 0) ? 1 : n) steps.push_back(OP_RX_BYTE);
    end
    abort_at = ($urandom_range(9) == 0) ? $urandom_range(steps.size() - 1) : steps.size();
    foreach (steps[i]) begin
      if (i == abort_at) begin
        send_op(OP_FAULT);
        return;
      end
      if (i > 0 && $urandom_range(99) < 15) send_noise(!cur_write && i >= 3);
      send_op(steps[i]);
    end
  endtask

  initial begin
    int unsigned phase_start;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    write_register(REG_UNUSED, 8'($urandom));
    configure(8'hFF, 1'b1, 5'd2);
    send_item(make_item(OP_LOAD, 8'h00, 4'd0));
    send_item(make_item(OP_LOAD, 8'hFF, 4'd15));
    send_item(make_item(OP_LOAD, 8'h5A, 4'd1));
    send_item(make_item(OP_TX_RDY, 8'hFF, 4'd15));
    send_item(make_item(OP_RX_BYTE, 8'hFF, 4'd15));
    send_item(make_item(OP_UNUSED_TOP, 8'h00, 4'd0));
    send_item(make_item(OP_START, 8'h00, 4'd0));
    send_item(make_item(OP_START, 8'hFF, 4'd15));
    send_item(make_item(OP_TX_RDY, 8'h00, 4'd0));
    send_item(make_item(OP_TX_RDY, 8'h00, 4'd0));
    send_item(make_item(OP_RX_BYTE, 8'hA5, 4'd5));
    send_item(make_item(OP_TX_RDY, 8'h00, 4'd0));
    send_item(make_item(OP_TX_RDY, 8'h00, 4'd0));
    send_item(make_item(OP_FAULT, 8'h00, 4'd0));
    send_item(make_item(OP_START, 8'h00, 4'd0));
    send_item(make_item(OP_FAULT, 8'hFF, 4'd15));
    send_item(make_item(OP_START, 8'h00, 4'd0));
    send_item(make_item(OP_TX_RDY, 8'h00, 4'd0));
    finish_phase();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     <= 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct     <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     <= 77;
        end
        default: begin
          send_idle_pct = 16;
          stall_pct     <= 16;
        end
      endcase
      if (p < PlanFixed) begin
        configure(PlanAddr[p], PlanWrite[p], PlanCount[p]);
      end else begin
        configure(8'($urandom), 1'($urandom),
                  ($urandom_range(7) == 0) ? 5'($urandom_range(31, 17))
                                           : 5'($urandom_range(16)));
      end
      if (p == 4 || p == 8) hold_requests <= hold_requests + 1;
      phase_start = events_sent;
      while (events_sent - phase_start < PhaseItems) begin
        if ($urandom_range(99) < 80) begin
          run_transaction();
        end else begin
          send_op(3'($urandom_range(OP_UNUSED_TOP)));
        end
      end
      finish_phase();
    end

    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
